// File: hw/rtl/fat_free_list_block_allocator_core_defines.svh
// Assertion helpers used by the allocator datapath.
`ifndef FAT_FREE_LIST_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define FAT_FREE_LIST_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define FFBA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ffba assertion failed");

// Next-cycle implication, sampled on clock and disabled during reset.
`define FFBA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ffba assertion failed");

`endif

// File: hw/rtl/ffba_pkg.sv
package ffba_pkg;

   localparam int MAX_BLOCKS = 1024;
   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int CNT_W      = IDX_W + 1;

   typedef enum logic [1:0] {
      MODE_FORMAT = 2'd0,
      MODE_ALLOC  = 2'd1,
      MODE_FREE   = 2'd2,
      MODE_QUERY  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_NOT_FORMATTED = 3'd1,
      ST_FULL          = 3'd2,
      ST_NO_BLOCK      = 3'd3,
      ST_RESERVED      = 3'd4,
      ST_NOT_ALLOCATED = 3'd5
   } status_type;

   // Table entry tag: a plain link, or one of the two marks.
   typedef enum logic [1:0] {
      TAG_LINK      = 2'd0,
      TAG_RESERVED  = 2'd1,
      TAG_ALLOCATED = 2'd2
   } tag_type;

   typedef enum logic [1:0] {
      CSR_N_BLOCKS       = 2'd0,
      CSR_RESERVED_COUNT = 2'd1
   } csr_index_type;

   typedef struct packed {
      tag_type          tag;
      logic [IDX_W-1:0] link;
   } entry_type;

   typedef struct packed {
      mode_type         mode;
      logic [IDX_W-1:0] block_index;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [IDX_W-1:0] granted_block;
      logic [CNT_W-1:0] free_blocks;
   } rsp_type;

   typedef struct packed {
      logic       accept;
      logic       fmt_start;
      logic       fmt_write;
      logic       rd_head;
      logic       rd_idx;
      logic       alloc_commit;
      logic       free_entry;
      logic       free_link;
      logic       rsp_load;
      status_type rsp_status;
      logic       rsp_grant;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     formatted;
      logic     idx_in_range;
      tag_type  entry_tag;
      logic     fmt_last;
      logic     rsp_slot_free;
   } dp_status_type;

endpackage

// File: hw/rtl/ffba_datapath.sv
`include "fat_free_list_block_allocator_core_defines.svh"

module ffba_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  ffba_pkg::req_type      req_payload,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output ffba_pkg::rsp_type      rsp_payload,
   input  logic                   csr_valid,
   input  ffba_pkg::csr_index_type csr_index,
   input  logic [ffba_pkg::CNT_W-1:0] csr_data,
   input  ffba_pkg::cmd_type      cmd,
   output ffba_pkg::dp_status_type sts
);

   logic [ffba_pkg::CNT_W-1:0] n_blocks_ff, n_blocks_in;
   logic [ffba_pkg::IDX_W-1:0] reserved_ff, reserved_in;
   logic [ffba_pkg::IDX_W-1:0] head_ff, head_in;
   logic [ffba_pkg::IDX_W-1:0] tail_ff, tail_in;
   logic [ffba_pkg::CNT_W-1:0] free_ff, free_in;
   logic                       formatted_ff, formatted_in;
   ffba_pkg::req_type          item_ff;
   logic [ffba_pkg::IDX_W-1:0] fmt_cnt_ff;
   logic [ffba_pkg::CNT_W-1:0] fmt_n_ff;
   logic [ffba_pkg::IDX_W-1:0] fmt_r_ff;
   logic [ffba_pkg::IDX_W-1:0] grant_ff;
   ffba_pkg::entry_type        rd_data_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   ffba_pkg::rsp_type          rsp_ff;

   ffba_pkg::entry_type        mem [ffba_pkg::MAX_BLOCKS];

   logic [ffba_pkg::CNT_W-1:0] n_sat;
   logic [ffba_pkg::IDX_W-1:0] r_eff;
   logic [ffba_pkg::CNT_W-1:0] fmt_pos;
   ffba_pkg::entry_type        fmt_entry;
   logic                       mem_we;
   logic [ffba_pkg::IDX_W-1:0] mem_waddr;
   ffba_pkg::entry_type        mem_wdata;
   logic                       mem_re;
   logic [ffba_pkg::IDX_W-1:0] mem_raddr;

   assign n_sat = (n_blocks_ff > ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS)) ?
                  ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS) : n_blocks_ff;
   assign r_eff = (reserved_ff == '0) ? ffba_pkg::IDX_W'(1) : reserved_ff;

   // Entry written at the current format position.
   assign fmt_pos = {1'b0, fmt_cnt_ff};
   always_comb begin
      fmt_entry.tag  = ffba_pkg::TAG_LINK;
      fmt_entry.link = '0;
      if (fmt_pos < {1'b0, fmt_r_ff} && fmt_pos < fmt_n_ff) begin
         fmt_entry.tag = ffba_pkg::TAG_RESERVED;
      end else if (fmt_pos + ffba_pkg::CNT_W'(1) < fmt_n_ff) begin
         fmt_entry.link = fmt_cnt_ff + ffba_pkg::IDX_W'(1);
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = fmt_cnt_ff;
      mem_wdata = fmt_entry;
      if (cmd.fmt_write) begin
         mem_we = 1'b1;
      end else if (cmd.alloc_commit) begin
         mem_we         = 1'b1;
         mem_waddr      = head_ff;
         mem_wdata.tag  = ffba_pkg::TAG_ALLOCATED;
         mem_wdata.link = '0;
      end else if (cmd.free_entry) begin
         mem_we         = 1'b1;
         mem_waddr      = item_ff.block_index;
         mem_wdata.tag  = ffba_pkg::TAG_LINK;
         mem_wdata.link = '0;
      end else if (cmd.free_link) begin
         // Append behind the old tail only when the list is not empty.
         mem_we         = (head_ff != '0);
         mem_waddr      = tail_ff;
         mem_wdata.tag  = ffba_pkg::TAG_LINK;
         mem_wdata.link = item_ff.block_index;
      end
   end

   assign mem_re    = cmd.rd_head | cmd.rd_idx;
   assign mem_raddr = cmd.rd_head ? head_ff : item_ff.block_index;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_comb begin
      n_blocks_in = n_blocks_ff;
      reserved_in = reserved_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ffba_pkg::CSR_N_BLOCKS:       n_blocks_in = csr_data;
            ffba_pkg::CSR_RESERVED_COUNT: reserved_in = csr_data[ffba_pkg::IDX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      free_in      = free_ff;
      formatted_in = formatted_ff;
      if (cmd.fmt_start) begin
         formatted_in = 1'b1;
         if ({1'b0, r_eff} >= n_sat) begin
            head_in = '0;
            tail_in = '0;
            free_in = '0;
         end else begin
            head_in = r_eff;
            tail_in = ffba_pkg::IDX_W'(n_sat - ffba_pkg::CNT_W'(1));
            free_in = n_sat - {1'b0, r_eff};
         end
      end else if (cmd.alloc_commit) begin
         head_in = rd_data_ff.link;
         if (rd_data_ff.link == '0) begin
            tail_in = '0;
         end
         if (free_ff != '0) begin
            free_in = free_ff - ffba_pkg::CNT_W'(1);
         end
      end else if (cmd.free_link) begin
         if (head_ff == '0) begin
            head_in = item_ff.block_index;
         end
         tail_in = item_ff.block_index;
         free_in = free_ff + ffba_pkg::CNT_W'(1);
      end
   end

   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         n_blocks_ff  <= ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS);
         reserved_ff  <= ffba_pkg::IDX_W'(2);
         head_ff      <= '0;
         tail_ff      <= '0;
         free_ff      <= '0;
         formatted_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         n_blocks_ff  <= n_blocks_in;
         reserved_ff  <= reserved_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         formatted_ff <= formatted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_ff <= req_payload;
      end
      if (cmd.fmt_start) begin
         fmt_cnt_ff <= '0;
         fmt_n_ff   <= n_sat;
         fmt_r_ff   <= r_eff;
      end else if (cmd.fmt_write) begin
         fmt_cnt_ff <= fmt_cnt_ff + ffba_pkg::IDX_W'(1);
      end
      if (cmd.alloc_commit) begin
         grant_ff <= head_ff;
      end
      if (cmd.rsp_load) begin
         rsp_ff.status        <= cmd.rsp_status;
         rsp_ff.granted_block <= cmd.rsp_grant ? grant_ff : '0;
         rsp_ff.free_blocks   <= free_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign sts.mode          = item_ff.mode;
   assign sts.formatted     = formatted_ff;
   assign sts.idx_in_range  = ({1'b0, item_ff.block_index} < n_sat);
   assign sts.entry_tag     = rd_data_ff.tag;
   assign sts.fmt_last      = (fmt_cnt_ff == ffba_pkg::IDX_W'(ffba_pkg::MAX_BLOCKS - 1));
   assign sts.rsp_slot_free = ~rsp_valid_ff | rsp_ready;

   `FFBA_ASSERT_NOW(a_load_into_free_slot, cmd.rsp_load, !rsp_valid_ff || rsp_ready)
   `FFBA_ASSERT_NEXT(a_formatted_sticks, formatted_ff, formatted_ff)
   `FFBA_ASSERT_NOW(a_empty_list_no_tail, formatted_ff && head_ff == '0, tail_ff == '0)
   `FFBA_ASSERT_NOW(a_alloc_from_link, cmd.alloc_commit, rd_data_ff.tag == ffba_pkg::TAG_LINK)

endmodule

// File: hw/rtl/ffba_ctrl.sv
module ffba_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ffba_pkg::dp_status_type sts,
   output ffba_pkg::cmd_type       cmd
);

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_DECODE    = 7'b0000010,
      S_FORMAT    = 7'b0000100,
      S_ALLOC_CHK = 7'b0001000,
      S_FREE_CHK  = 7'b0010000,
      S_FREE_LINK = 7'b0100000,
      S_RESP      = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   ffba_pkg::status_type status_ff, status_in;
   logic                 grant_ff, grant_in;

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      grant_in  = grant_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            status_in = ffba_pkg::ST_OK;
            grant_in  = 1'b0;
            priority if (sts.mode == ffba_pkg::MODE_FORMAT) begin
               cmd.fmt_start = 1'b1;
               state_in      = S_FORMAT;
            end else if (!sts.formatted) begin
               status_in = ffba_pkg::ST_NOT_FORMATTED;
               state_in  = S_RESP;
            end else if (sts.mode == ffba_pkg::MODE_ALLOC) begin
               cmd.rd_head = 1'b1;
               state_in    = S_ALLOC_CHK;
            end else if (sts.mode == ffba_pkg::MODE_FREE) begin
               if (sts.idx_in_range) begin
                  cmd.rd_idx = 1'b1;
                  state_in   = S_FREE_CHK;
               end else begin
                  status_in = ffba_pkg::ST_NO_BLOCK;
                  state_in  = S_RESP;
               end
            end else begin
               state_in = S_RESP;
            end
         end
         S_FORMAT: begin
            cmd.fmt_write = 1'b1;
            if (sts.fmt_last) begin
               state_in = S_RESP;
            end
         end
         S_ALLOC_CHK: begin
            if (sts.entry_tag == ffba_pkg::TAG_LINK) begin
               cmd.alloc_commit = 1'b1;
               grant_in         = 1'b1;
            end else begin
               status_in = ffba_pkg::ST_FULL;
            end
            state_in = S_RESP;
         end
         S_FREE_CHK: begin
            priority if (sts.entry_tag == ffba_pkg::TAG_RESERVED) begin
               status_in = ffba_pkg::ST_RESERVED;
               state_in  = S_RESP;
            end else if (sts.entry_tag == ffba_pkg::TAG_ALLOCATED) begin
               cmd.free_entry = 1'b1;
               state_in       = S_FREE_LINK;
            end else begin
               status_in = ffba_pkg::ST_NOT_ALLOCATED;
               state_in  = S_RESP;
            end
         end
         S_FREE_LINK: begin
            cmd.free_link = 1'b1;
            state_in      = S_RESP;
         end
         S_RESP: begin
            cmd.rsp_status = status_ff;
            cmd.rsp_grant  = grant_ff;
            if (sts.rsp_slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= ffba_pkg::ST_OK;
         grant_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         grant_ff  <= grant_in;
      end
   end

endmodule

// File: hw/rtl/fat_free_list_block_allocator_core.sv
// Each item is decoded, then runs its mode's steps: query, unformatted and out-of-range items
// go straight to the result; allocate checks the list head; a free checks the entry's mark and
// relinks an allocated block; format writes 1024 entries, one per cycle. One item is in flight
// at a time and the next is accepted the cycle after the result is loaded. The result waits in
// an output register; only a result still untaken there stalls the next. Synchronous reset:
// control registers return to defaults, state is unformatted, table is undefined.
module fat_free_list_block_allocator_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  ffba_pkg::req_type           req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output ffba_pkg::rsp_type           rsp_payload,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  ffba_pkg::csr_index_type     csr_index,
   input  logic [ffba_pkg::CNT_W-1:0]  csr_data
);

   ffba_pkg::cmd_type       cmd;
   ffba_pkg::dp_status_type sts;

   assign csr_ready = 1'b1;

   ffba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ffba_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

// File: tb/tb_fat_free_list_block_allocator_core.sv
`timescale 1ns / 1ps

module tb_fat_free_list_block_allocator_core;

   localparam int unsigned CYCLE_LIMIT = 500_000;
   localparam int unsigned SEG_ITEMS   = 81;

   typedef struct {
      logic                            is_csr;
      ffba_pkg::csr_index_type         csr_idx;
      logic [ffba_pkg::CNT_W-1:0]      csr_val;
      ffba_pkg::req_type               item;
      logic                            typed;
      ffba_pkg::rsp_type               want;
   } plan_step_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   ffba_pkg::req_type           req_payload;
   logic                        rsp_valid;
   logic                        rsp_ready;
   ffba_pkg::rsp_type           rsp_payload;
   logic                        csr_valid;
   logic                        csr_ready;
   ffba_pkg::csr_index_type     csr_index;
   logic [ffba_pkg::CNT_W-1:0]  csr_data;

   // Shadow of the allocation table and its bookkeeping.
   ffba_pkg::entry_type         fat_tbl [ffba_pkg::MAX_BLOCKS];
   logic [ffba_pkg::IDX_W-1:0]  fl_head;
   logic [ffba_pkg::IDX_W-1:0]  fl_tail;
   logic [ffba_pkg::CNT_W-1:0]  free_cnt;
   logic                        is_formatted;
   logic [ffba_pkg::CNT_W-1:0]  cfg_n_blocks;
   logic [ffba_pkg::IDX_W-1:0]  cfg_reserved;

   ffba_pkg::rsp_type           want_q [$];
   ffba_pkg::rsp_type           oldest_want;
   int unsigned                 mismatches;
   int unsigned                 cycle_cnt;
   int unsigned                 send_idle_pct;
   int unsigned                 rsp_stall_pct;

   fat_free_list_block_allocator_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic int unsigned blocks_in_use();
      return (cfg_n_blocks > ffba_pkg::MAX_BLOCKS) ? ffba_pkg::MAX_BLOCKS : int'(cfg_n_blocks);
   endfunction

   // Updates the shadow table for one item and returns the result it should produce.
   function automatic ffba_pkg::rsp_type apply_table_op(input ffba_pkg::req_type item);
      ffba_pkg::rsp_type          res;
      int unsigned                used;
      int unsigned                rsv;
      ffba_pkg::entry_type        ent;
      logic [ffba_pkg::IDX_W-1:0] p;

      res        = '0;
      res.status = ffba_pkg::ST_OK;
      used       = blocks_in_use();
      if (item.mode == ffba_pkg::MODE_FORMAT) begin
         rsv = (cfg_reserved == 0) ? 1 : int'(cfg_reserved);
         for (int i = 0; i < ffba_pkg::MAX_BLOCKS; i++)
            fat_tbl[i] = '{tag: ffba_pkg::TAG_LINK, link: '0};
         if (rsv >= used) begin
            for (int i = 0; i < used; i++) fat_tbl[i].tag = ffba_pkg::TAG_RESERVED;
            fl_head  = '0;
            fl_tail  = '0;
            free_cnt = '0;
         end else begin
            for (int i = 0; i < rsv; i++) fat_tbl[i].tag = ffba_pkg::TAG_RESERVED;
            for (int i = rsv; i + 1 < used; i++) fat_tbl[i].link = ffba_pkg::IDX_W'(i + 1);
            fl_head  = ffba_pkg::IDX_W'(rsv);
            fl_tail  = ffba_pkg::IDX_W'(used - 1);
            free_cnt = ffba_pkg::CNT_W'(used - rsv);
         end
         is_formatted = 1'b1;
      end else if (!is_formatted) begin
         res.status = ffba_pkg::ST_NOT_FORMATTED;
      end else if (item.mode == ffba_pkg::MODE_ALLOC) begin
         p   = fl_head;
         ent = fat_tbl[p];
         if (ent.tag != ffba_pkg::TAG_LINK) begin
            res.status = ffba_pkg::ST_FULL;
         end else begin
            fl_head    = ent.link;
            fat_tbl[p] = '{tag: ffba_pkg::TAG_ALLOCATED, link: '0};
            if (ent.link == 0) fl_tail = '0;
            if (free_cnt > 0) free_cnt = free_cnt - 1'b1;
            res.granted_block = p;
         end
      end else if (item.mode == ffba_pkg::MODE_FREE) begin
         if (item.block_index >= used) begin
            res.status = ffba_pkg::ST_NO_BLOCK;
         end else if (fat_tbl[item.block_index].tag == ffba_pkg::TAG_RESERVED) begin
            res.status = ffba_pkg::ST_RESERVED;
         end else if (fat_tbl[item.block_index].tag == ffba_pkg::TAG_ALLOCATED) begin
            fat_tbl[item.block_index] = '{tag: ffba_pkg::TAG_LINK, link: '0};
            // An empty list gets the block as its new head; otherwise it goes behind the tail.
            if (fl_head == 0) fl_head = item.block_index;
            else fat_tbl[fl_tail] = '{tag: ffba_pkg::TAG_LINK, link: item.block_index};
            fl_tail  = item.block_index;
            free_cnt = free_cnt + 1'b1;
         end else begin
            res.status = ffba_pkg::ST_NOT_ALLOCATED;
         end
      end
      res.free_blocks = free_cnt;
      return res;
   endfunction

   function automatic plan_step_type item_row(input ffba_pkg::mode_type m,
                                              input int unsigned idx);
      plan_step_type s;
      s.is_csr           = 1'b0;
      s.csr_idx          = ffba_pkg::CSR_N_BLOCKS;
      s.csr_val          = '0;
      s.item.mode        = m;
      s.item.block_index = ffba_pkg::IDX_W'(idx);
      s.typed            = 1'b0;
      s.want             = '0;
      return s;
   endfunction

   function automatic plan_step_type known_row(input ffba_pkg::mode_type m,
                                               input int unsigned idx,
                                               input ffba_pkg::status_type st,
                                               input int unsigned grant,
                                               input int unsigned nfree);
      plan_step_type s;
      s                    = item_row(m, idx);
      s.typed              = 1'b1;
      s.want.status        = st;
      s.want.granted_block = ffba_pkg::IDX_W'(grant);
      s.want.free_blocks   = ffba_pkg::CNT_W'(nfree);
      return s;
   endfunction

   function automatic plan_step_type csr_row(input ffba_pkg::csr_index_type ci,
                                             input int unsigned val);
      plan_step_type s;
      s         = item_row(ffba_pkg::MODE_QUERY, 0);
      s.is_csr  = 1'b1;
      s.csr_idx = ci;
      s.csr_val = ffba_pkg::CNT_W'(val);
      return s;
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is taken,
   // with valid still high so that a following item can go out back to back.
   task automatic push_item(input ffba_pkg::req_type item, input logic typed,
                            input ffba_pkg::rsp_type typed_want);
      ffba_pkg::rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_payload = item;
      do @(posedge clock); while (!req_ready);
      predicted = apply_table_op(item);
      want_q.push_back(typed ? typed_want : predicted);
      @(negedge clock);
   endtask

   // Registers change only once the block has returned every pending result.
   task automatic write_csr(input ffba_pkg::csr_index_type ci,
                            input logic [ffba_pkg::CNT_W-1:0] val);
      req_valid = 1'b0;
      while (want_q.size() != 0) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = ci;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      case (ci)
         ffba_pkg::CSR_N_BLOCKS:       cfg_n_blocks = val;
         ffba_pkg::CSR_RESERVED_COUNT: cfg_reserved = val[ffba_pkg::IDX_W-1:0];
         default:                      ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (want_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: status %0d granted %0d free %0d",
                        rsp_payload.status, rsp_payload.granted_block,
                        rsp_payload.free_blocks);
         end else begin
            oldest_want = want_q.pop_front();
            if (rsp_payload.status !== oldest_want.status ||
                rsp_payload.granted_block !== oldest_want.granted_block ||
                rsp_payload.free_blocks !== oldest_want.free_blocks) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected status %0d granted %0d free %0d, got %0d %0d %0d",
                           oldest_want.status, oldest_want.granted_block,
                           oldest_want.free_blocks, rsp_payload.status,
                           rsp_payload.granted_block, rsp_payload.free_blocks);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("fat_free_list_block_allocator_core regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      plan_step_type               plan_q [$];
      logic [ffba_pkg::IDX_W-1:0]  taken_q [$];
      ffba_pkg::req_type           item;
      int unsigned                 seg;
      int unsigned                 pick;
      int unsigned                 used;
      int unsigned                 n_val;
      int unsigned                 r_val;
      logic                        do_format;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_payload   = '0;
      csr_valid     = 1'b0;
      csr_index     = ffba_pkg::CSR_N_BLOCKS;
      csr_data      = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      fl_head       = '0;
      fl_tail       = '0;
      free_cnt      = '0;
      is_formatted  = 1'b0;
      cfg_n_blocks  = ffba_pkg::CNT_W'(1024);
      cfg_reserved  = ffba_pkg::IDX_W'(2);
      for (int i = 0; i < ffba_pkg::MAX_BLOCKS; i++)
         fat_tbl[i] = '{tag: ffba_pkg::TAG_LINK, link: '0};

      // Nothing works before a format; then the default layout and the marks.
      plan_q.push_back(known_row(ffba_pkg::MODE_QUERY, 0, ffba_pkg::ST_NOT_FORMATTED, 0, 0));
      plan_q.push_back(known_row(ffba_pkg::MODE_ALLOC, 1023, ffba_pkg::ST_NOT_FORMATTED, 0, 0));
      plan_q.push_back(known_row(ffba_pkg::MODE_FREE, 1023, ffba_pkg::ST_NOT_FORMATTED, 0, 0));
      plan_q.push_back(known_row(ffba_pkg::MODE_FORMAT, 0, ffba_pkg::ST_OK, 0, 1022));
      plan_q.push_back(known_row(ffba_pkg::MODE_ALLOC, 0, ffba_pkg::ST_OK, 2, 1021));
      plan_q.push_back(known_row(ffba_pkg::MODE_ALLOC, 1023, ffba_pkg::ST_OK, 3, 1020));
      plan_q.push_back(known_row(ffba_pkg::MODE_FREE, 0, ffba_pkg::ST_RESERVED, 0, 1020));
      plan_q.push_back(known_row(ffba_pkg::MODE_FREE, 1, ffba_pkg::ST_RESERVED, 0, 1020));
      plan_q.push_back(known_row(ffba_pkg::MODE_FREE, 1023, ffba_pkg::ST_NOT_ALLOCATED,
                                 0, 1020));
      plan_q.push_back(item_row(ffba_pkg::MODE_FREE, 2));
      plan_q.push_back(known_row(ffba_pkg::MODE_FREE, 2, ffba_pkg::ST_NOT_ALLOCATED, 0, 1021));
      plan_q.push_back(item_row(ffba_pkg::MODE_ALLOC, 0));
      plan_q.push_back(item_row(ffba_pkg::MODE_QUERY, 1023));
      // A zero reserved count still keeps block 0 out of the list.
      plan_q.push_back(csr_row(ffba_pkg::CSR_N_BLOCKS, 4));
      plan_q.push_back(csr_row(ffba_pkg::CSR_RESERVED_COUNT, 0));
      plan_q.push_back(known_row(ffba_pkg::MODE_FORMAT, 0, ffba_pkg::ST_OK, 0, 3));
      plan_q.push_back(known_row(ffba_pkg::MODE_ALLOC, 0, ffba_pkg::ST_OK, 1, 2));
      plan_q.push_back(known_row(ffba_pkg::MODE_ALLOC, 0, ffba_pkg::ST_OK, 2, 1));
      plan_q.push_back(known_row(ffba_pkg::MODE_ALLOC, 0, ffba_pkg::ST_OK, 3, 0));
      plan_q.push_back(known_row(ffba_pkg::MODE_ALLOC, 0, ffba_pkg::ST_FULL, 0, 0));
      plan_q.push_back(known_row(ffba_pkg::MODE_FREE, 4, ffba_pkg::ST_NO_BLOCK, 0, 0));
      plan_q.push_back(item_row(ffba_pkg::MODE_FREE, 2));
      plan_q.push_back(item_row(ffba_pkg::MODE_ALLOC, 0));
      // Reserved count covering every block leaves the list empty.
      plan_q.push_back(csr_row(ffba_pkg::CSR_RESERVED_COUNT, 11'h7FF));
      plan_q.push_back(known_row(ffba_pkg::MODE_FORMAT, 0, ffba_pkg::ST_OK, 0, 0));
      plan_q.push_back(known_row(ffba_pkg::MODE_ALLOC, 0, ffba_pkg::ST_FULL, 0, 0));
      // Block count above the table size saturates.
      plan_q.push_back(csr_row(ffba_pkg::CSR_N_BLOCKS, 2047));
      plan_q.push_back(csr_row(ffba_pkg::CSR_RESERVED_COUNT, 2));
      plan_q.push_back(known_row(ffba_pkg::MODE_FORMAT, 0, ffba_pkg::ST_OK, 0, 1022));
      plan_q.push_back(known_row(ffba_pkg::MODE_ALLOC, 0, ffba_pkg::ST_OK, 2, 1021));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan_q[k]) begin
         if (plan_q[k].is_csr) write_csr(plan_q[k].csr_idx, plan_q[k].csr_val);
         else push_item(plan_q[k].item, plan_q[k].typed, plan_q[k].want);
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 57; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 57; end
            default: begin send_idle_pct = 11; rsp_stall_pct = 11; end
         endcase
         for (int s = 0; s < 4; s++) begin
            seg = phase * 4 + s;
            case (seg)
               0: begin n_val = 2;    r_val = 1;     end
               1: begin n_val = 2047; r_val = 0;     end
               2: begin n_val = 0;    r_val = 5;     end
               3: begin n_val = 1024; r_val = 1023;  end
               4: begin n_val = 1;    r_val = 1;     end
               5: begin n_val = 1025; r_val = 'h400; end
               default: begin
                  pick = $urandom_range(9);
                  if (pick < 6) n_val = $urandom_range(2, 40);
                  else if (pick < 8) n_val = $urandom_range(41, 1024);
                  else n_val = $urandom_range(0, 2047);
                  pick = $urandom_range(9);
                  if (pick < 6) r_val = $urandom_range(0, 8);
                  else if (pick < 8) r_val = $urandom_range(0, (n_val > 1023) ? 1023 : n_val);
                  else r_val = $urandom_range(0, 2047);
               end
            endcase
            write_csr(ffba_pkg::CSR_N_BLOCKS, ffba_pkg::CNT_W'(n_val));
            write_csr(ffba_pkg::CSR_RESERVED_COUNT, ffba_pkg::CNT_W'(r_val));
            // Now and then the old table is kept under the new block count.
            do_format = (seg < 6) || ($urandom_range(99) < 85);
            if (do_format) begin
               item.mode        = ffba_pkg::MODE_FORMAT;
               item.block_index = ffba_pkg::IDX_W'($urandom_range(1023));
               push_item(item, 1'b0, '0);
            end
            for (int k = 0; k < SEG_ITEMS; k++) begin
               item.block_index = ffba_pkg::IDX_W'($urandom_range(1023));
               pick = $urandom_range(99);
               used = blocks_in_use();
               if (pick < 2) begin
                  item.mode = ffba_pkg::MODE_FORMAT;
               end else if (pick < 47) begin
                  item.mode = ffba_pkg::MODE_ALLOC;
               end else if (pick < 90) begin
                  item.mode = ffba_pkg::MODE_FREE;
                  pick = $urandom_range(9);
                  if (pick < 7) begin
                     // Mostly give back a block that is really out on loan.
                     taken_q.delete();
                     foreach (fat_tbl[b])
                        if (fat_tbl[b].tag == ffba_pkg::TAG_ALLOCATED)
                           taken_q.push_back(ffba_pkg::IDX_W'(b));
                     if (taken_q.size() != 0)
                        item.block_index = taken_q[$urandom_range(taken_q.size() - 1)];
                  end else if (pick < 8 && used > 0) begin
                     item.block_index = ffba_pkg::IDX_W'($urandom_range(used - 1));
                  end
               end else begin
                  item.mode = ffba_pkg::MODE_QUERY;
               end
               push_item(item, 1'b0, '0);
            end
         end
      end

      req_valid = 1'b0;
      while (want_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && want_q.size() == 0) begin
         $display("fat_free_list_block_allocator_core regression: pass");
      end else begin
         $display("fat_free_list_block_allocator_core regression: fail");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_datapath.sv
hw/rtl/ffba_ctrl.sv
hw/rtl/fat_free_list_block_allocator_core.sv
tb/tb_fat_free_list_block_allocator_core.sv
